[hdl/line_substring_filter_assert.svh]
// Assertion macros for the line substring filter.
`ifndef LINE_SUBSTRING_FILTER_ASSERT_SVH
`define LINE_SUBSTRING_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LSF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line_substring_filter check failed");
`define LSF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line_substring_filter check failed");
`else
`define LSF_ASSERT_NOW(label, ante, cons)
`define LSF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hdl/lsf_pkg.sv]
package lsf_pkg;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	localparam logic KIND_REPORT  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam logic [2:0] REG_PATTERN_LENGTH      = 3'd0;
	localparam logic [2:0] REG_PATTERN_FIRST_EIGHT = 3'd1;
	localparam logic [2:0] REG_PATTERN_LAST_EIGHT  = 3'd2;
	localparam logic [2:0] REG_INVERT_MATCH        = 3'd3;
	localparam logic [2:0] REG_TALLY_ONLY          = 3'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic op;
		logic [7:0] text_byte;
	} lsf_in_t;

	typedef struct packed {
		logic result_kind;
		logic [31:0] line_number;
		logic [31:0] selected_total;
		logic none_selected;
		logic last_of_run;
	} lsf_out_t;

	typedef struct packed {
		logic first;
		logic second;
	} lsf_push_t;

endpackage

[hdl/lsf_cell.sv]
module lsf_cell #(
	parameter int IDX = 0,
	parameter int LENW = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  logic clear,
	input  logic [7:0] text_byte,
	input  logic [7:0] pattern_byte,
	input  logic prev_match,
	input  logic [LENW-1:0] eff_len,
	output logic match,
	output logic hit
);

	logic match_q;
	logic match_next;

	assign match_next = prev_match & (text_byte == pattern_byte);
	assign hit = match_next & (eff_len == LENW'(IDX + 1));
	assign match = match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (clear) begin
			match_q <= 1'b0;
		end else if (shift) begin
			match_q <= match_next;
		end
	end

endmodule

[hdl/lsf_result_queue.sv]
module lsf_result_queue import lsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  lsf_push_t push,
	input  lsf_out_t res_first,
	input  lsf_out_t res_second,
	output logic room,
	output logic out_valid,
	input  logic out_stall,
	output lsf_out_t out_item
);

	lsf_out_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic pop;

	assign out_valid = (count_q != '0);
	assign out_item = mem_q[rd_q];
	assign pop = out_valid & ~out_stall;
	assign room = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= res_first;
		end
		if (push.second) begin
			mem_q[wr_q + QPTR_W'(1)] <= res_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + QPTR_W'(push.first) + QPTR_W'(push.second);
			rd_q <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.first) + QCNT_W'(push.second) - QCNT_W'(pop);
		end
	end

endmodule

[hdl/line_substring_filter.sv]
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_item    (op, text_byte)
// out       out_valid / out_stall  out_item   (report or summary)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input item per cycle while in_stall is low; the row of match cells advances on every nonzero searchable byte.
// Results enter a four-entry queue in the accepting cycle and are registered there before they show on out.
// in_stall rises while fewer than two queue slots are free (end of stream may give two).
// Reset clears configuration, line state, counters and queue; no clearing pass.
// cfg_ready is always high; write registers only while idle.
`include "line_substring_filter_assert.svh"

module line_substring_filter import lsf_pkg::*; #(
	parameter int PATTERN_MAX = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lsf_in_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output lsf_out_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int LENW = $clog2(PATTERN_MAX + 1);

	logic [4:0] pattern_length_q;
	logic [63:0] pattern_first_q;
	logic [63:0] pattern_last_q;
	logic invert_q;
	logic tally_only_q;

	logic open_q;
	logic found_q;
	logic zero_q;
	logic [31:0] line_q;
	logic [31:0] sel_q;

	logic [LENW-1:0] eff_len;
	logic [7:0] pat_row [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] match_row;
	logic [PATTERN_MAX-1:0] hit_row;

	logic room;
	logic accepted;
	logic is_byte;
	logic is_nl;
	logic is_end;
	logic searchable;
	logic shift;
	logic clear;
	logic judge;
	logic selected;
	logic report;
	logic [31:0] line_inc;
	logic [31:0] sel_inc;
	logic [31:0] sel_after;
	lsf_out_t report_item;
	lsf_out_t summary_item;
	lsf_push_t push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			pattern_first_q <= '0;
			pattern_last_q <= '0;
			invert_q <= 1'b0;
			tally_only_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				REG_PATTERN_FIRST_EIGHT: pattern_first_q <= cfg_data;
				REG_PATTERN_LAST_EIGHT: pattern_last_q <= cfg_data;
				REG_INVERT_MATCH: invert_q <= cfg_data[0];
				REG_TALLY_ONLY: tally_only_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(pattern_length_q) > 32'(PATTERN_MAX)) begin
			eff_len = LENW'(PATTERN_MAX);
		end else begin
			eff_len = LENW'(pattern_length_q);
		end
	end

	assign in_stall = ~room;
	assign accepted = in_valid & ~in_stall;
	assign is_byte = (in_item.op == OP_BYTE);
	assign is_end = (in_item.op == OP_END);
	assign is_nl = is_byte & (in_item.text_byte == NEWLINE_BYTE);
	assign searchable = is_byte & ~is_nl & ~zero_q;
	assign shift = accepted & searchable & (in_item.text_byte != 8'd0);
	assign clear = accepted & (is_nl | is_end);

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic prev_match;
		if (k < 8) begin : g_first
			assign pat_row[k] = pattern_first_q[8*k +: 8];
		end else if (k < 16) begin : g_last
			assign pat_row[k] = pattern_last_q[8*(k-8) +: 8];
		end else begin : g_none
			assign pat_row[k] = 8'd0;
		end
		if (k == 0) begin : g_head
			assign prev_match = 1'b1;
		end else begin : g_link
			assign prev_match = match_row[k-1];
		end
		lsf_cell #(
			.IDX(k),
			.LENW(LENW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift(shift),
			.clear(clear),
			.text_byte(in_item.text_byte),
			.pattern_byte(pat_row[k]),
			.prev_match(prev_match),
			.eff_len(eff_len),
			.match(match_row[k]),
			.hit(hit_row[k])
		);
	end

	assign judge = accepted & (is_nl | (is_end & open_q));
	assign selected = ((eff_len == '0) | found_q) ^ invert_q;
	assign report = judge & selected & ~tally_only_q;
	assign line_inc = (line_q == COUNT_MAX) ? line_q : line_q + 32'd1;
	assign sel_inc = (selected && sel_q != COUNT_MAX) ? sel_q + 32'd1 : sel_q;
	assign sel_after = judge ? sel_inc : sel_q;

	always_comb begin
		report_item.result_kind = KIND_REPORT;
		report_item.line_number = line_inc;
		report_item.selected_total = sel_inc;
		report_item.none_selected = 1'b0;
		report_item.last_of_run = is_nl;
		summary_item.result_kind = KIND_SUMMARY;
		summary_item.line_number = 32'd0;
		summary_item.selected_total = sel_after;
		summary_item.none_selected = (sel_after == 32'd0);
		summary_item.last_of_run = 1'b1;
	end

	assign push.first = report | (accepted & is_end);
	assign push.second = report & is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			found_q <= 1'b0;
			zero_q <= 1'b0;
			line_q <= '0;
			sel_q <= '0;
		end else if (accepted) begin
			if (is_end) begin
				open_q <= 1'b0;
				found_q <= 1'b0;
				zero_q <= 1'b0;
				line_q <= '0;
				sel_q <= '0;
			end else if (is_nl) begin
				open_q <= 1'b0;
				found_q <= 1'b0;
				zero_q <= 1'b0;
				line_q <= line_inc;
				sel_q <= sel_inc;
			end else begin
				open_q <= 1'b1;
				if (searchable && in_item.text_byte == 8'd0) begin
					zero_q <= 1'b1;
				end
				if (shift && (hit_row != '0)) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	lsf_result_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.res_first(report ? report_item : summary_item),
		.res_second(summary_item),
		.room(room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	`LSF_ASSERT_NOW(a_sel_within_lines, 1'b1, sel_q <= line_q)
	`LSF_ASSERT_NEXT(a_end_clears_counts, accepted && is_end, line_q == '0 && sel_q == '0)
	`LSF_ASSERT_NEXT(a_newline_closes_line, accepted && is_nl, !open_q && !found_q && !zero_q)

endmodule
